// ----- rtl/stc_pkg.sv -----
`timescale 1ns / 1ps

package stc_pkg;

   // Table size and the intensity bits taken from each sample.
   localparam int TABLE_DEPTH = 1024;
   localparam int SAMPLE_BITS = 16;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // Field widths of the channel words.
   localparam int WAVE_W   = 10;
   localparam int VALUE_W  = 16;
   localparam int LEVEL_W  = (SAMPLE_BITS < VALUE_W) ? SAMPLE_BITS : VALUE_W;
   localparam logic [VALUE_W-1:0] LEVEL_MASK = VALUE_W'((64'd1 << LEVEL_W) - 64'd1);

   // Table entry: valid mark above the three matching values.
   localparam int ENTRY_W = 3 * VALUE_W + 1;

   // Accumulator, total and quotient widths.
   localparam int PROD_W  = 2 * VALUE_W;
   localparam int ACC_W   = 48;
   localparam int TOTAL_W = ACC_W + 2;
   localparam int QUO_W   = 17;
   localparam int DIV_STEPS = QUO_W;
   localparam int STEP_W  = $clog2(DIV_STEPS);

   // Item kinds carried by the mode field.
   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   typedef struct packed {
      logic                mode;
      logic [WAVE_W-1:0]   wavelength;
      logic [VALUE_W-1:0]  intensity;
      logic [VALUE_W-1:0]  match_x;
      logic [VALUE_W-1:0]  match_y;
      logic [VALUE_W-1:0]  match_z;
      logic                last_sample;
   } stc_req_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  chroma_x;
      logic [VALUE_W-1:0]  chroma_y;
      logic                zero_sum;
   } stc_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_ACCUM,
      ST_TOTAL,
      ST_DIVIDE,
      ST_DONE
   } stc_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              clear_wr;
      logic [ADDR_W-1:0] clear_addr;
      logic              load_wr;
      logic              sample_rd;
      logic              do_lookup;
      logic              do_accum;
      logic              do_total;
      logic              div_step;
      logic              div_first;
      logic              out_load;
   } stc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;
      logic out_free;
   } stc_status_type;

endpackage

// ----- rtl/stc_ctrl.sv -----
`timescale 1ns / 1ps

module stc_ctrl
   import stc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_mode,
   output logic           req_stall,
   input  stc_status_type status,
   output stc_cmd_type    cmd
);

   stc_state_type      state_ff, state_in;
   logic [ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   // State, clearing counter and divide step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
         step_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         step_ff    <= step_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      step_in        = step_ff;
      cmd            = '0;
      cmd.clear_addr = clr_cnt_ff;
      req_stall      = 1'b1;

      unique case (state_ff)
         ST_CLEAR: begin
            // One table entry is invalidated per cycle after reset.
            cmd.clear_wr = 1'b1;
            if (clr_cnt_ff == ADDR_W'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            end
         end
         ST_IDLE, ST_ACCUM: begin
            // The accumulate of the previous sample overlaps the next accept,
            // unless that sample closes a spectrum.
            if (state_ff == ST_ACCUM) begin
               cmd.do_accum = 1'b1;
            end
            if (state_ff == ST_ACCUM && status.last) begin
               state_in = ST_TOTAL;
            end else begin
               req_stall = 1'b0;
               state_in  = ST_IDLE;
               if (req_valid) begin
                  if (req_mode == MODE_LOAD) begin
                     cmd.load_wr = 1'b1;
                  end else begin
                     cmd.sample_rd = 1'b1;
                     state_in      = ST_LOOKUP;
                  end
               end
            end
         end
         ST_LOOKUP: begin
            cmd.do_lookup = 1'b1;
            state_in      = ST_ACCUM;
         end
         ST_TOTAL: begin
            cmd.do_total = 1'b1;
            step_in      = '0;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = (step_ff == '0);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DONE: begin
            // Wait for room in the output register.
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/stc_datapath.sv -----
`timescale 1ns / 1ps

module stc_datapath
   import stc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  stc_cmd_type    cmd,
   input  stc_req_type    req_word,
   input  logic           rsp_stall,
   output stc_status_type status,
   output logic           rsp_valid,
   output stc_rsp_type    rsp_word
);

   // Saturating add of a product into an accumulator.
   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                 input logic [PROD_W-1:0] add);
      logic [ACC_W:0] s;
      s = {1'b0, acc} + (ACC_W + 1)'(add);
      return s[ACC_W] ? '1 : s[ACC_W-1:0];
   endfunction

   // One restoring division step: the top bit is the quotient bit.
   function automatic logic [TOTAL_W:0] div_step(input logic [TOTAL_W-1:0] rem,
                                                 input logic [TOTAL_W-1:0] den,
                                                 input logic             first);
      logic [TOTAL_W:0] shifted;
      logic [TOTAL_W:0] diff;
      logic             ge;
      shifted = first ? {1'b0, rem} : {rem, 1'b0};
      diff    = shifted - {1'b0, den};
      ge      = (shifted >= {1'b0, den});
      return {ge, ge ? diff[TOTAL_W-1:0] : shifted[TOTAL_W-1:0]};
   endfunction

   logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

   logic [ADDR_W-1:0]  req_addr;
   logic               req_in_range;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               wr_en;

   logic [ENTRY_W-1:0] rd_ff;
   logic               range_ff;
   logic [VALUE_W-1:0] level_ff;
   logic               last_ff;
   logic               hit;

   logic [PROD_W-1:0]  prod_x_ff, prod_y_ff, prod_z_ff;
   logic [ACC_W-1:0]   sum_x_ff, sum_y_ff, sum_z_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] rem_x_ff, rem_y_ff;
   logic [QUO_W-1:0]   quo_x_ff, quo_y_ff;
   logic [TOTAL_W:0]   step_x, step_y;

   logic               rsp_valid_ff;
   stc_rsp_type        rsp_word_ff;
   logic               zero_total;

   // Table address from the wavelength; wavelengths past the table never hit.
   assign req_addr     = ADDR_W'(req_word.wavelength);
   assign req_in_range = (32'(req_word.wavelength) < TABLE_DEPTH);

   // Single write port shared by the clearing pass and table loads.
   assign wr_en   = cmd.clear_wr || (cmd.load_wr && req_in_range);
   assign wr_addr = cmd.clear_wr ? cmd.clear_addr : req_addr;
   assign wr_data = cmd.clear_wr ? '0
                  : {1'b1, req_word.match_z, req_word.match_y, req_word.match_x};

   // Table memory with valid mark in the top bit, registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.sample_rd) begin
         rd_ff <= mem[req_addr];
      end
   end

   // Sample fields held for the lookup and accumulate cycles.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 1'b0;
      end else if (cmd.sample_rd) begin
         last_ff <= req_word.last_sample;
      end
      if (cmd.sample_rd) begin
         range_ff <= req_in_range;
         level_ff <= req_word.intensity & LEVEL_MASK;
      end
   end

   // Products of the matching values with the intensity.
   assign hit = rd_ff[ENTRY_W-1] && range_ff;

   always_ff @(posedge clock) begin
      if (cmd.do_lookup) begin
         prod_x_ff <= hit ? PROD_W'(rd_ff[VALUE_W-1:0]) * PROD_W'(level_ff) : '0;
         prod_y_ff <= hit ? PROD_W'(rd_ff[2*VALUE_W-1:VALUE_W]) * PROD_W'(level_ff) : '0;
         prod_z_ff <= hit ? PROD_W'(rd_ff[3*VALUE_W-1:2*VALUE_W]) * PROD_W'(level_ff)
                          : '0;
      end
   end

   // Saturating accumulators, cleared once the total is taken.
   always_ff @(posedge clock) begin
      if (reset || cmd.do_total) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         sum_z_ff <= '0;
      end else if (cmd.do_accum) begin
         sum_x_ff <= sat_add(sum_x_ff, prod_x_ff);
         sum_y_ff <= sat_add(sum_y_ff, prod_y_ff);
         sum_z_ff <= sat_add(sum_z_ff, prod_z_ff);
      end
   end

   // Two divider lanes share the total as divisor.
   assign step_x = div_step(rem_x_ff, total_ff, cmd.div_first);
   assign step_y = div_step(rem_y_ff, total_ff, cmd.div_first);

   always_ff @(posedge clock) begin
      if (cmd.do_total) begin
         total_ff <= TOTAL_W'(sum_x_ff) + TOTAL_W'(sum_y_ff) + TOTAL_W'(sum_z_ff);
         rem_x_ff <= TOTAL_W'(sum_x_ff);
         rem_y_ff <= TOTAL_W'(sum_y_ff);
      end else if (cmd.div_step) begin
         rem_x_ff <= step_x[TOTAL_W-1:0];
         rem_y_ff <= step_y[TOTAL_W-1:0];
         quo_x_ff <= {quo_x_ff[QUO_W-2:0], step_x[TOTAL_W]};
         quo_y_ff <= {quo_y_ff[QUO_W-2:0], step_y[TOTAL_W]};
      end
   end

   // Output register; a full share saturates to the largest code.
   assign zero_total = (total_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_word_ff.zero_sum <= zero_total;
         rsp_word_ff.chroma_x <= zero_total ? '0
                               : (quo_x_ff[QUO_W-1] ? '1 : quo_x_ff[VALUE_W-1:0]);
         rsp_word_ff.chroma_y <= zero_total ? '0
                               : (quo_y_ff[QUO_W-1] ? '1 : quo_y_ff[VALUE_W-1:0]);
      end
   end

   assign status.last     = last_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word        = rsp_word_ff;

endmodule

// ----- rtl/spectrum_to_chromaticity.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Handshake          Word
// req      in         req_valid/stall    mode, wavelength, intensity, match_x/y/z, last_sample
// rsp      out        rsp_valid/stall    chroma_x, chroma_y, zero_sum
//
// A table load is written as it is taken, and a spectral sample passes through
// the table read, then the multiply; the accumulate overlaps the next accept.
// A sample that closes a spectrum then passes through its own accumulate, the
// total, two restoring divider lanes that share the total as divisor and form x
// and y, one bit per cycle, and the load of the output register.
// After reset the table is invalidated in a pass over all TABLE_DEPTH entries
// (1024), during which req_stall stays high.
// A result waits in the output register while rsp_stall is high; new words are
// still taken unless another spectrum finishes first.

module spectrum_to_chromaticity
   import stc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  stc_req_type req_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output stc_rsp_type rsp_word
);

   stc_cmd_type    cmd;
   stc_status_type status;

   // Sequencer.
   stc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_word.mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Table, accumulators, divider and output register.
   stc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_word  (req_word),
      .rsp_stall (rsp_stall),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // The clearing pass holds off the input channel from the cycle after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_stall)
      else $error("input accepted during table clearing pass");

   // A result is only loaded when the output register can take it.
   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result overwrote an untaken word");

   // Clearing never shares the table port with a load or a read.
   a_clear_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_wr |-> (!cmd.load_wr && !cmd.sample_rd && req_stall))
      else $error("table access during clearing pass");

   // A spectrum result follows an accumulate of a closing sample.
   a_total_after_last: assert property (@(posedge clock) disable iff (reset)
      cmd.do_total |-> $past(cmd.do_accum) && $past(status.last))
      else $error("total taken without a closing sample");

endmodule

// ----- verif/spectrum_to_chromaticity_tb.sv -----
`timescale 1ns / 1ps

module spectrum_to_chromaticity_tb;
   import stc_pkg::*;

   localparam int QUIET_LIMIT      = 4000;
   localparam int REPORT_LIMIT     = 10;
   localparam int PHASE_WORDS      = 420;
   localparam int WAVE_MAX         = (1 << WAVE_W) - 1;
   localparam bit [ACC_W-1:0]   ACC_FULL   = '1;
   localparam bit [VALUE_W-1:0] VALUE_FULL = '1;

   // Tracks the matching table and the three sums, and holds the chromaticity
   // words that the accepted samples should produce, oldest first.
   class chroma_scoreboard;
      bit [3*VALUE_W-1:0] match_store [TABLE_DEPTH];
      bit                 entry_loaded [TABLE_DEPTH];
      bit [ACC_W-1:0]     sum_x;
      bit [ACC_W-1:0]     sum_y;
      bit [ACC_W-1:0]     sum_z;
      stc_rsp_type        chroma_q [$];
      int                 mismatches;
      int                 loads_seen;
      int                 samples_seen;
      int                 results_seen;

      // Adds one product, holding the sum at its largest value on overflow.
      function bit [ACC_W-1:0] add_saturating(bit [ACC_W-1:0] acc, bit [63:0] product);
         bit [63:0] s;
         s = 64'(acc) + product;
         return (s > 64'(ACC_FULL)) ? ACC_FULL : s[ACC_W-1:0];
      endfunction

      // Truncated Q0.16 share of the total; a whole share is held at the top code.
      function bit [VALUE_W-1:0] share_of(bit [63:0] part, bit [63:0] total);
         bit [63:0] q;
         q = (part << 16) / total;
         return (q > 64'(VALUE_FULL)) ? VALUE_FULL : q[VALUE_W-1:0];
      endfunction

      function void note_word(stc_req_type w);
         bit [63:0]          level;
         bit [63:0]          total;
         bit [3*VALUE_W-1:0] entry;
         stc_rsp_type        e;
         if (w.mode == MODE_LOAD) begin
            loads_seen++;
            if (int'(w.wavelength) < TABLE_DEPTH) begin
               match_store[w.wavelength] = {w.match_z, w.match_y, w.match_x};
               entry_loaded[w.wavelength] = 1'b1;
            end
            return;
         end
         samples_seen++;
         level = 64'(w.intensity & LEVEL_MASK);
         if (int'(w.wavelength) < TABLE_DEPTH && entry_loaded[w.wavelength]) begin
            entry = match_store[w.wavelength];
            sum_x = add_saturating(sum_x, 64'(entry[VALUE_W-1:0]) * level);
            sum_y = add_saturating(sum_y, 64'(entry[2*VALUE_W-1:VALUE_W]) * level);
            sum_z = add_saturating(sum_z, 64'(entry[3*VALUE_W-1:2*VALUE_W]) * level);
         end
         if (!w.last_sample) return;
         // The end of a spectrum: form x and y, then start afresh.
         total = 64'(sum_x) + 64'(sum_y) + 64'(sum_z);
         if (total == 0) begin
            e.chroma_x = '0;
            e.chroma_y = '0;
            e.zero_sum = 1'b1;
         end else begin
            e.chroma_x = share_of(64'(sum_x), total);
            e.chroma_y = share_of(64'(sum_y), total);
            e.zero_sum = 1'b0;
         end
         chroma_q = {chroma_q, e};
         sum_x = '0;
         sum_y = '0;
         sum_z = '0;
      endfunction

      function void check_result(stc_rsp_type r);
         stc_rsp_type e;
         if (chroma_q.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
               $display("Unexpected chromaticity word: x=%h y=%h zero_sum=%b",
                        r.chroma_x, r.chroma_y, r.zero_sum);
            mismatches++;
            return;
         end
         e = chroma_q.pop_front();
         results_seen++;
         if (r.chroma_x !== e.chroma_x || r.chroma_y !== e.chroma_y
             || r.zero_sum !== e.zero_sum) begin
            if (mismatches < REPORT_LIMIT)
               $display({"Chromaticity mismatch: expected x=%h y=%h zero_sum=%b,",
                         " got x=%h y=%h zero_sum=%b"},
                        e.chroma_x, e.chroma_y, e.zero_sum,
                        r.chroma_x, r.chroma_y, r.zero_sum);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return chroma_q.size();
      endfunction
   endclass

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   stc_req_type req_word  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   stc_rsp_type rsp_word;

   chroma_scoreboard chroma_sb = new;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int quiet_cycles  = 0;
   bit wl_loaded [TABLE_DEPTH];
   int loaded_wl [$];

   spectrum_to_chromaticity DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver back-pressure at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // Watches both channels; a cycle with no word moving counts towards the timeout.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) chroma_sb.note_word(req_word);
      if (!reset && rsp_valid && !rsp_stall) chroma_sb.check_result(rsp_word);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   // Mostly random values, with the two extremes turning up often.
   function automatic bit [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return VALUE_FULL;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // Table load; the sample fields carry noise that the block must ignore.
   function automatic stc_req_type load_word(int wl, bit [VALUE_W-1:0] mx,
                                             bit [VALUE_W-1:0] my, bit [VALUE_W-1:0] mz);
      stc_req_type w;
      w.mode        = MODE_LOAD;
      w.wavelength  = WAVE_W'(wl);
      w.intensity   = VALUE_W'($urandom);
      w.match_x     = mx;
      w.match_y     = my;
      w.match_z     = mz;
      w.last_sample = 1'($urandom);
      return w;
   endfunction

   // Spectral sample; the matching fields carry noise.
   function automatic stc_req_type sample_word(int wl, bit [VALUE_W-1:0] level, bit ends);
      stc_req_type w;
      w.mode        = MODE_SAMPLE;
      w.wavelength  = WAVE_W'(wl);
      w.intensity   = level;
      w.match_x     = VALUE_W'($urandom);
      w.match_y     = VALUE_W'($urandom);
      w.match_z     = VALUE_W'($urandom);
      w.last_sample = ends;
      return w;
   endfunction

   // Mostly wavelengths that hold an entry, now and then any wavelength at all.
   function automatic int pick_wavelength();
      if (loaded_wl.size() != 0 && $urandom_range(0, 99) < 85)
         return loaded_wl[$urandom_range(0, loaded_wl.size() - 1)];
      return $urandom_range(0, WAVE_MAX);
   endfunction

   // Offers one word, now and then after a random gap, and holds it until it is taken.
   task automatic send_word(input stc_req_type w);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      if (w.mode == MODE_LOAD && !wl_loaded[w.wavelength]) begin
         wl_loaded[w.wavelength] = 1'b1;
         loaded_wl = {loaded_wl, int'(w.wavelength)};
      end
   endtask

   // Holds the sender back until every chromaticity word has come out.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (chroma_sb.outstanding() != 0);
   endtask

   // Mostly whole spectra of random length, with table rewrites and stray
   // samples that carry no end mark mixed in.
   task automatic run_random_phase(input int words);
      int sent;
      int length;
      sent = 0;
      while (sent < words) begin
         case ($urandom_range(0, 9))
            0: begin
               repeat ($urandom_range(1, 4)) begin
                  send_word(load_word($urandom_range(0, WAVE_MAX), random_value(),
                                      random_value(), random_value()));
                  sent++;
               end
            end
            1: begin
               send_word(sample_word(pick_wavelength(), random_value(), 1'b0));
               sent++;
            end
            default: begin
               length = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(1, 12);
               for (int i = 1; i <= length; i++) begin
                  send_word(sample_word(pick_wavelength(), random_value(), i == length));
                  sent++;
               end
            end
         endcase
      end
   endtask

   initial begin
      send_idle_pct = 28;
      rsp_stall_pct = 69;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed spectra. A sample at an empty wavelength still closes a spectrum.
      send_word(sample_word(5, VALUE_FULL, 1'b1));
      send_word(load_word(0, VALUE_FULL, VALUE_FULL, VALUE_FULL));
      send_word(load_word(WAVE_MAX, 16'h0000, 16'h0000, 16'h0000));
      send_word(load_word(512, 16'h4000, 16'h0000, 16'h0000));
      send_word(load_word(100, 16'h0000, 16'h8000, 16'h0000));
      send_word(load_word(200, 16'h0000, 16'h0000, 16'h0001));
      send_word(load_word(700, 16'h1234, 16'h5678, 16'h9abc));
      // Equal shares, then zero sums from an all-zero entry and from zero intensity.
      send_word(sample_word(0, VALUE_FULL, 1'b1));
      send_word(sample_word(WAVE_MAX, VALUE_FULL, 1'b1));
      send_word(sample_word(0, 16'h0000, 1'b1));
      // One component holding the whole sum.
      send_word(sample_word(512, 16'h0001, 1'b1));
      send_word(sample_word(100, VALUE_FULL, 1'b1));
      send_word(sample_word(200, VALUE_FULL, 1'b1));
      // A short spectrum closed by a sample at an empty wavelength.
      send_word(sample_word(0, 16'd100, 1'b0));
      send_word(sample_word(700, 16'd200, 1'b0));
      send_word(sample_word(300, VALUE_FULL, 1'b1));
      // Rewriting an entry replaces the old triple.
      send_word(load_word(512, 16'h0001, 16'h0002, VALUE_FULL));
      send_word(sample_word(512, 16'h8000, 1'b1));
      wait_for_results();

      // Load 40 random table entries before the random spectra.
      repeat (40)
         send_word(load_word($urandom_range(0, WAVE_MAX), random_value(),
                             random_value(), random_value()));
      run_random_phase(PHASE_WORDS);
      wait_for_results();

      send_idle_pct = 69;
      rsp_stall_pct = 28;
      run_random_phase(PHASE_WORDS);
      wait_for_results();

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_random_phase(PHASE_WORDS);
      wait_for_results();
      repeat (30) @(posedge clock);

      chroma_sb.mismatches += chroma_sb.outstanding();
      $display("Covered %0d table loads and %0d spectral samples under three stall mixes.",
               chroma_sb.loads_seen, chroma_sb.samples_seen);
      $display("Checked %0d chromaticity words, %0d mismatches.",
               chroma_sb.results_seen, chroma_sb.mismatches);
      if (chroma_sb.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
